### hdl/sfid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the state-feedback duty controller.
// Holds the sample and result payloads, command codes and saturation helper.
package sfid_pkg;

	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I1  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I2  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_VC  = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_VO  = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET   = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_KI       = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BIAS     = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_TURNS    = 4'd7;

	localparam logic signed [31:0] TURNS_RESET = 32'sh0001_0000;

	localparam logic signed [63:0] SAT_HI   = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] SAT_LO   = -64'sh0000_0000_8000_0000;
	localparam logic signed [63:0] DUTY_MAX = 64'sd65535;

	typedef enum logic {
		CMD_SAMPLE  = 1'b0,
		CMD_RESTART = 1'b1
	} sample_cmd_t;

	typedef enum logic [1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_HIGH = 2'd1,
		CLAMP_LOW  = 2'd2
	} clamp_t;

	typedef enum logic [2:0] {
		MUL_TURNS,
		MUL_I1,
		MUL_I2,
		MUL_VC,
		MUL_VO,
		MUL_KI
	} mul_sel_t;

	typedef struct packed {
		sample_cmd_t        cmd;
		logic signed [15:0] current_one;
		logic signed [15:0] current_two;
		logic signed [15:0] cap_voltage_one;
		logic signed [15:0] cap_voltage_two;
		logic signed [15:0] out_voltage;
		logic signed [15:0] out_reference;
	} sample_t;

	typedef struct packed {
		logic [15:0] duty;
		clamp_t      clamp_state;
	} result_t;

	typedef struct packed {
		logic     capture;
		logic     restart;
		mul_sel_t mul_sel;
		logic     acc_clr;
		logic     acc_add;
		logic     vc_load;
		logic     integ_upd;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > SAT_HI) begin
			r = SAT_HI[31:0];
		end else if (x < SAT_LO) begin
			r = SAT_LO[31:0];
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

### hdl/sfid_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the duty controller: steps the shared multiplier through one sample.
// Depends on sfid_pkg for the command and status types.
module sfid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  sfid_pkg::sample_cmd_t sample_cmd,
	output logic              sample_stall,
	input  sfid_pkg::dp_sts_t dp_sts,
	output sfid_pkg::dp_cmd_t dp_cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TURNS,
		ST_I1,
		ST_I2,
		ST_VC,
		ST_VO,
		ST_KI,
		ST_INTEG,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   accept;

	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (sample_cmd == sfid_pkg::CMD_SAMPLE)) begin
						state_q <= ST_TURNS;
					end
				end
				ST_TURNS: state_q <= ST_I1;
				ST_I1:    state_q <= ST_I2;
				ST_I2:    state_q <= ST_VC;
				ST_VC:    state_q <= ST_VO;
				ST_VO:    state_q <= ST_KI;
				ST_KI:    state_q <= ST_INTEG;
				ST_INTEG: state_q <= ST_OUT;
				ST_OUT: begin
					if (dp_sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		dp_cmd           = '0;
		dp_cmd.mul_sel   = sfid_pkg::MUL_TURNS;
		dp_cmd.capture   = accept && (sample_cmd == sfid_pkg::CMD_SAMPLE);
		dp_cmd.restart   = accept && (sample_cmd == sfid_pkg::CMD_RESTART);
		unique case (state_q)
			ST_IDLE: ;
			ST_TURNS: begin
				dp_cmd.mul_sel = sfid_pkg::MUL_TURNS;
				dp_cmd.acc_clr = 1'b1;
			end
			ST_I1: begin
				dp_cmd.mul_sel = sfid_pkg::MUL_I1;
				dp_cmd.vc_load = 1'b1;
			end
			ST_I2: begin
				dp_cmd.mul_sel = sfid_pkg::MUL_I2;
				dp_cmd.acc_add = 1'b1;
			end
			ST_VC: begin
				dp_cmd.mul_sel = sfid_pkg::MUL_VC;
				dp_cmd.acc_add = 1'b1;
			end
			ST_VO: begin
				dp_cmd.mul_sel = sfid_pkg::MUL_VO;
				dp_cmd.acc_add = 1'b1;
			end
			ST_KI: begin
				dp_cmd.mul_sel = sfid_pkg::MUL_KI;
				dp_cmd.acc_add = 1'b1;
			end
			ST_INTEG: dp_cmd.integ_upd = 1'b1;
			ST_OUT:   dp_cmd.out_load  = dp_sts.out_free;
			default: ;
		endcase
	end

endmodule

### hdl/sfid_datapath.sv
`timescale 1ns / 1ps
// Datapath of the duty controller: registers, one shared multiplier, accumulator,
// integrator and output register. Depends on sfid_pkg.
module sfid_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [sfid_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [sfid_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  sfid_pkg::sample_t                     sample_data,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output sfid_pkg::result_t                     result_data,
	input  sfid_pkg::dp_cmd_t                     dp_cmd,
	output sfid_pkg::dp_sts_t                     dp_sts
);

	logic signed [31:0] gain_i1_q;
	logic signed [31:0] gain_i2_q;
	logic signed [31:0] gain_vc_q;
	logic signed [31:0] gain_vo_q;
	logic signed [31:0] offset_q;
	logic signed [31:0] ki_q;
	logic        [15:0] bias_q;
	logic signed [31:0] turns_q;

	sfid_pkg::sample_t  sample_q;
	logic signed [65:0] prod_q;
	logic signed [67:0] acc_q;
	logic signed [32:0] vc_q;
	logic signed [59:0] ud_q;
	logic signed [31:0] integ_q;
	logic               primed_q;
	logic               result_valid_q;
	sfid_pkg::result_t  result_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic signed [16:0] err;
	logic signed [59:0] ud;
	logic signed [63:0] ud_ext;
	logic signed [63:0] integ_sum;
	logic signed [63:0] u;
	logic signed [63:0] u_ext_ud;
	logic signed [63:0] u_ext_integ;

	// Output register frees when its request is taken in the same cycle.
	assign dp_sts.out_free = !result_valid_q || !result_stall;
	assign result_valid    = result_valid_q;
	assign result_data     = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_i1_q <= '0;
			gain_i2_q <= '0;
			gain_vc_q <= '0;
			gain_vo_q <= '0;
			offset_q  <= '0;
			ki_q      <= '0;
			bias_q    <= '0;
			turns_q   <= sfid_pkg::TURNS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sfid_pkg::REG_GAIN_I1: gain_i1_q <= cfg_data;
				sfid_pkg::REG_GAIN_I2: gain_i2_q <= cfg_data;
				sfid_pkg::REG_GAIN_VC: gain_vc_q <= cfg_data;
				sfid_pkg::REG_GAIN_VO: gain_vo_q <= cfg_data;
				sfid_pkg::REG_OFFSET:  offset_q  <= cfg_data;
				sfid_pkg::REG_KI:      ki_q      <= cfg_data;
				sfid_pkg::REG_BIAS:    bias_q    <= cfg_data[15:0];
				sfid_pkg::REG_TURNS:   turns_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign err = {sample_q.out_reference[15], sample_q.out_reference}
		- {sample_q.out_voltage[15], sample_q.out_voltage};

	always_comb begin
		unique case (dp_cmd.mul_sel)
			sfid_pkg::MUL_TURNS: begin
				mul_a = {turns_q[31], turns_q};
				mul_b = {{17{sample_q.cap_voltage_two[15]}}, sample_q.cap_voltage_two};
			end
			sfid_pkg::MUL_I1: begin
				mul_a = {gain_i1_q[31], gain_i1_q};
				mul_b = {{17{sample_q.current_one[15]}}, sample_q.current_one};
			end
			sfid_pkg::MUL_I2: begin
				mul_a = {gain_i2_q[31], gain_i2_q};
				mul_b = {{17{sample_q.current_two[15]}}, sample_q.current_two};
			end
			sfid_pkg::MUL_VC: begin
				mul_a = {gain_vc_q[31], gain_vc_q};
				mul_b = vc_q;
			end
			sfid_pkg::MUL_VO: begin
				mul_a = {gain_vo_q[31], gain_vo_q};
				mul_b = {{17{sample_q.out_voltage[15]}}, sample_q.out_voltage};
			end
			sfid_pkg::MUL_KI: begin
				mul_a = {ki_q[31], ki_q};
				mul_b = {{16{err[16]}}, err};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign ud        = acc_q[67:8];
	assign ud_ext    = {{4{ud[59]}}, ud};
	assign integ_sum = {{32{integ_q[31]}}, integ_q} + {{6{prod_q[65]}}, prod_q[65:8]};

	assign u_ext_ud    = {{4{ud_q[59]}}, ud_q};
	assign u_ext_integ = {{32{integ_q[31]}}, integ_q};
	assign u           = {48'd0, bias_q} - u_ext_ud - u_ext_integ;

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			sample_q <= sample_data;
		end
		prod_q <= mul_p;
		if (dp_cmd.acc_clr) begin
			acc_q <= -({{36{offset_q[31]}}, offset_q} <<< 8);
		end else if (dp_cmd.acc_add) begin
			acc_q <= acc_q + {{2{prod_q[65]}}, prod_q};
		end
		if (dp_cmd.vc_load) begin
			vc_q <= {{17{sample_q.cap_voltage_one[15]}}, sample_q.cap_voltage_one}
				+ prod_q[48:16];
		end
		if (dp_cmd.integ_upd) begin
			ud_q <= ud;
		end
		if (dp_cmd.out_load) begin
			if (u > sfid_pkg::DUTY_MAX) begin
				result_q.duty        <= 16'hFFFF;
				result_q.clamp_state <= sfid_pkg::CLAMP_HIGH;
			end else if (u < 64'sd0) begin
				result_q.duty        <= 16'h0000;
				result_q.clamp_state <= sfid_pkg::CLAMP_LOW;
			end else begin
				result_q.duty        <= u[15:0];
				result_q.clamp_state <= sfid_pkg::CLAMP_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q        <= '0;
			primed_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.restart) begin
				integ_q  <= '0;
				primed_q <= 1'b0;
			end else if (dp_cmd.integ_upd) begin
				primed_q <= 1'b1;
				if (!primed_q) begin
					integ_q <= sfid_pkg::sat32(-ud_ext);
				end else begin
					integ_q <= sfid_pkg::sat32(integ_sum);
				end
			end
			if (dp_cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/state_feedback_integral_duty_unit.sv
`timescale 1ns / 1ps
// State-feedback duty controller with integral action: a sequencer and a datapath.
// A control sample runs through six passes of the one shared 33 by 33 bit multiplier,
// an integrator update and the output load; a stalled result holds the sequencer in its
// last step, and the next request is taken only once it is back in idle. A restart
// request clears integrator and priming flag. Asynchronous reset clears both, the result
// flag and the configuration registers but loads TURNS_RESET into the turns register.
module state_feedback_integral_duty_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_stall,
	input  sfid_pkg::sample_t                sample_data,
	output logic                             result_valid,
	input  logic                             result_stall,
	output sfid_pkg::result_t                result_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sfid_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sfid_pkg::CFG_DATA_W-1:0]  cfg_data
);

	sfid_pkg::dp_cmd_t dp_cmd;
	sfid_pkg::dp_sts_t dp_sts;

	assign cfg_ready = 1'b1;

	sfid_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_cmd   (sample_data.cmd),
		.sample_stall (sample_stall),
		.dp_sts       (dp_sts),
		.dp_cmd       (dp_cmd)
	);

	sfid_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data),
		.dp_cmd       (dp_cmd),
		.dp_sts       (dp_sts)
	);

	// A control sample keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall && (sample_data.cmd == sfid_pkg::CMD_SAMPLE))
		|=> sample_stall)
		else $error("Block took a new request while a sample was in work.");

	// A result only appears after the sequencer loaded the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(dp_cmd.out_load))
		else $error("Result appeared without an output load.");

	// The output register is never overwritten while its request is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> (!result_valid || !result_stall))
		else $error("Output register loaded over a stalled result.");

	// A high clamp always reports full duty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_data.clamp_state == sfid_pkg::CLAMP_HIGH))
		|-> (result_data.duty == 16'hFFFF))
		else $error("High clamp with a duty below full scale.");

endmodule
